// ===== sv/rect_circle_collision_test_top_macros.svh =====
// Assertion macros for the rect/circle collision test block.
// Used by rect_circle_collision_test_top; depends on a clock named clk and reset rst.
`ifndef RECT_CIRCLE_COLLISION_TEST_TOP_MACROS_SVH
`define RECT_CIRCLE_COLLISION_TEST_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RCC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("collision test: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define RCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("collision test: next-cycle check failed");

`endif

// ===== sv/rccol_pkg.sv =====
// Package for the rect/circle collision test: widths, types, operation codes
// and the absolute-difference helper. Depends on nothing.
package rccol_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int EXT_BITS   = COORD_BITS + 1;      // coordinate plus size
  localparam int MAG_BITS   = COORD_BITS + 1;      // magnitude of an edge-to-centre gap
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;
  localparam int RSQ_BITS   = 2 * SIZE_BITS;
  localparam int OP_BITS    = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [SIZE_BITS-1:0]  size_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;
  typedef logic signed [EXT_BITS:0]     wide_t;
  typedef logic        [MAG_BITS-1:0]   mag_t;
  typedef logic        [SQ_BITS-1:0]    sq_t;
  typedef logic        [SUM_BITS-1:0]   sum_t;
  typedef logic        [RSQ_BITS-1:0]   rsq_t;
  typedef logic        [OP_BITS-1:0]    op_t;

  localparam op_t OP_RECT_RECT     = 2'd0;
  localparam op_t OP_RECT_CIRCLE   = 2'd1;
  localparam op_t OP_CIRCLE_CIRCLE = 2'd2;

  // |a - b|, exact; the gap always fits MAG_BITS
  function automatic mag_t abs_diff(ext_t a, ext_t b);
    wide_t d;
    d = wide_t'(a) - wide_t'(b);
    return d[EXT_BITS] ? mag_t'(-d) : mag_t'(d);
  endfunction

endpackage

// ===== sv/rect_circle_collision_test_top.sv =====
// Rect/rect and rect/circle collision test, four-register pipeline.
// Depends on rccol_pkg and rect_circle_collision_test_top_macros.svh.
//
//  channel   handshake            payload
//  --------  -------------------  --------------------------------------------
//  input     start && !busy       operation, a_*, b_*, circle_x/y, circle_radius
//  result    done (one cycle)     hit
//
// One item is taken every cycle; busy is always low.
// Each item passes in turn through the input register,
// edge/gap stage, squaring stage (the 17x17 multipliers) and compare stage.
// Results leave in the order items arrived. rst (synchronous) empties the
// pipeline; items in flight are dropped. The receiver cannot stall.
`include "rect_circle_collision_test_top_macros.svh"

module rect_circle_collision_test_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  rccol_pkg::op_t         operation,
  input  rccol_pkg::coord_t      a_x,
  input  rccol_pkg::coord_t      a_y,
  input  rccol_pkg::size_t       a_w,
  input  rccol_pkg::size_t       a_h,
  input  rccol_pkg::coord_t      b_x,
  input  rccol_pkg::coord_t      b_y,
  input  rccol_pkg::size_t       b_w,
  input  rccol_pkg::size_t       b_h,
  input  rccol_pkg::coord_t      circle_x,
  input  rccol_pkg::coord_t      circle_y,
  input  rccol_pkg::size_t       circle_radius,
  output logic                   done,
  output logic                   hit
);

  // stage A: input register
  logic                v_a;
  rccol_pkg::op_t      op_a;
  rccol_pkg::coord_t   ax_a, ay_a, bx_a, by_a, cx_a, cy_a;
  rccol_pkg::size_t    aw_a, ah_a, bw_a, bh_a, r_a;

  // stage B: gaps and rect/rect answer
  logic                v_b;
  logic                is_rr_b, is_rc_b, rr_hit_b;
  rccol_pkg::mag_t     far_dx, far_dy, near_dx, near_dy;
  rccol_pkg::size_t    r_b;

  // stage C: squares
  logic                v_c;
  logic                is_rr_c, is_rc_c, rr_hit_c;
  rccol_pkg::sq_t      far_sx, far_sy, near_sx, near_sy;
  rccol_pkg::rsq_t     rsq_c;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else begin
      v_a <= start && !busy;
    end
    if (start && !busy) begin
      op_a <= operation;
      ax_a <= a_x;
      ay_a <= a_y;
      aw_a <= a_w;
      ah_a <= a_h;
      bx_a <= b_x;
      by_a <= b_y;
      bw_a <= b_w;
      bh_a <= b_h;
      cx_a <= circle_x;
      cy_a <= circle_y;
      r_a  <= circle_radius;
    end
  end

  // edges, far and near gaps per axis, inclusive rect overlap
  rccol_pkg::ext_t  ax_lo, ax_hi, ay_lo, ay_hi, bx_lo, bx_hi, by_lo, by_hi;
  rccol_pkg::ext_t  px, py;
  rccol_pkg::mag_t  gx_lo, gx_hi, gy_lo, gy_hi;
  rccol_pkg::mag_t  far_dx_next, far_dy_next, near_dx_next, near_dy_next;
  logic             apart;

  always_comb begin
    ax_lo = rccol_pkg::ext_t'(ax_a);
    ay_lo = rccol_pkg::ext_t'(ay_a);
    bx_lo = rccol_pkg::ext_t'(bx_a);
    by_lo = rccol_pkg::ext_t'(by_a);
    ax_hi = ax_lo + rccol_pkg::ext_t'({1'b0, aw_a});
    ay_hi = ay_lo + rccol_pkg::ext_t'({1'b0, ah_a});
    bx_hi = bx_lo + rccol_pkg::ext_t'({1'b0, bw_a});
    by_hi = by_lo + rccol_pkg::ext_t'({1'b0, bh_a});
    px    = rccol_pkg::ext_t'(cx_a);
    py    = rccol_pkg::ext_t'(cy_a);

    apart = (ax_lo > bx_hi) || (ax_hi < bx_lo) || (ay_lo > by_hi) || (ay_hi < by_lo);

    gx_lo = rccol_pkg::abs_diff(ax_lo, px);
    gx_hi = rccol_pkg::abs_diff(ax_hi, px);
    gy_lo = rccol_pkg::abs_diff(ay_lo, py);
    gy_hi = rccol_pkg::abs_diff(ay_hi, py);

    // far corner: larger gap on each axis (a tie gives the same gap)
    far_dx_next = (gx_hi > gx_lo) ? gx_hi : gx_lo;
    far_dy_next = (gy_hi > gy_lo) ? gy_hi : gy_lo;

    // nearest point: centre clamped into the rect
    if (px > ax_hi) begin
      near_dx_next = gx_hi;
    end else if (px < ax_lo) begin
      near_dx_next = gx_lo;
    end else begin
      near_dx_next = '0;
    end
    if (py > ay_hi) begin
      near_dy_next = gy_hi;
    end else if (py < ay_lo) begin
      near_dy_next = gy_lo;
    end else begin
      near_dy_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else begin
      v_b <= v_a;
    end
    is_rr_b  <= (op_a == rccol_pkg::OP_RECT_RECT);
    is_rc_b  <= (op_a == rccol_pkg::OP_RECT_CIRCLE);
    rr_hit_b <= !apart;
    far_dx   <= far_dx_next;
    far_dy   <= far_dy_next;
    near_dx  <= near_dx_next;
    near_dy  <= near_dy_next;
    r_b      <= r_a;
  end

  // squares, operands widened to the full product width
  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else begin
      v_c <= v_b;
    end
    is_rr_c  <= is_rr_b;
    is_rc_c  <= is_rc_b;
    rr_hit_c <= rr_hit_b;
    far_sx   <= rccol_pkg::sq_t'(far_dx) * rccol_pkg::sq_t'(far_dx);
    far_sy   <= rccol_pkg::sq_t'(far_dy) * rccol_pkg::sq_t'(far_dy);
    near_sx  <= rccol_pkg::sq_t'(near_dx) * rccol_pkg::sq_t'(near_dx);
    near_sy  <= rccol_pkg::sq_t'(near_dy) * rccol_pkg::sq_t'(near_dy);
    rsq_c    <= rccol_pkg::rsq_t'(r_b) * rccol_pkg::rsq_t'(r_b);
  end

  // distance compares and final selection
  rccol_pkg::sum_t far_sum, near_sum, rsq_ext;
  logic            hit_next;

  always_comb begin
    far_sum  = rccol_pkg::sum_t'(far_sx) + rccol_pkg::sum_t'(far_sy);
    near_sum = rccol_pkg::sum_t'(near_sx) + rccol_pkg::sum_t'(near_sy);
    rsq_ext  = rccol_pkg::sum_t'(rsq_c);
    if (is_rr_c) begin
      hit_next = rr_hit_c;
    end else if (is_rc_c) begin
      // far corner strictly inside means the outline is missed
      hit_next = !(far_sum < rsq_ext) && (near_sum <= rsq_ext);
    end else begin
      hit_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_c;
    end
    hit <= hit_next;
  end

  // checks
  `RCC_ASSERT_IMPL(a_done_latency, done, $past(start, 4))
  `RCC_ASSERT_IMPL(a_hit_op, done && hit, $past(operation, 4) <= rccol_pkg::OP_RECT_CIRCLE)
  `RCC_ASSERT_IMPL(a_near_le_far, v_b, near_dx <= far_dx && near_dy <= far_dy)
  `RCC_ASSERT_NEXT(a_pipe_flow, v_b, v_c)

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for rect_circle_collision_test_top: directed edge cases, then a
// random stream of rect/rect and rect/circle queries checked against an in-bench predictor.
// Depends on rccol_pkg and the RTL of the block.
module tb_top;

  // Selector value with no shape pairing behind it; answers like circle/circle
  localparam rccol_pkg::op_t OP_UNUSED = 2'd3;
  localparam int  STALL_LIMIT    = 200;
  localparam int  PIPE_DRAIN     = 8;
  localparam int  RANDOM_QUERIES = 1650;

  typedef struct {
    rccol_pkg::op_t    operation;
    rccol_pkg::coord_t a_x, a_y;
    rccol_pkg::size_t  a_w, a_h;
    rccol_pkg::coord_t b_x, b_y;
    rccol_pkg::size_t  b_w, b_h;
    rccol_pkg::coord_t circle_x, circle_y;
    rccol_pkg::size_t  circle_radius;
  } query_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  rccol_pkg::op_t    operation = rccol_pkg::OP_RECT_RECT;
  rccol_pkg::coord_t a_x = '0, a_y = '0, b_x = '0, b_y = '0, circle_x = '0, circle_y = '0;
  rccol_pkg::size_t  a_w = '0, a_h = '0, b_w = '0, b_h = '0, circle_radius = '0;
  logic              done;
  logic              hit;

  bit     expected_hits[$];
  int     mismatch_count = 0;
  int     idle_cycles = 0;
  bit     burst_mode = 1'b0;

  rect_circle_collision_test_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation),
    .a_x(a_x), .a_y(a_y), .a_w(a_w), .a_h(a_h),
    .b_x(b_x), .b_y(b_y), .b_w(b_w), .b_h(b_h),
    .circle_x(circle_x), .circle_y(circle_y), .circle_radius(circle_radius),
    .done(done), .hit(hit)
  );

  always #5 clk = ~clk;

  // Picks the rect edge farther from p on one axis; a tie keeps the low edge
  function automatic longint far_edge_of(longint lo, longint len, longint p);
    longint d_hi, d_lo;
    d_hi = lo + len - p;
    d_lo = lo - p;
    return (d_hi * d_hi > d_lo * d_lo) ? lo + len : lo;
  endfunction

  function automatic longint clamp_to_edge(longint lo, longint len, longint p);
    if (p > lo + len) return lo + len;
    if (p < lo) return lo;
    return p;
  endfunction

  function automatic longint dist_sq(longint px, longint py, longint cx, longint cy);
    return (px - cx) * (px - cx) + (py - cy) * (py - cy);
  endfunction

  // Expected hit bit for one query, exact 64-bit arithmetic
  function automatic bit collision_hit(query_t q);
    longint ax, ay, aw, ah, bx, by, bw, bh, cx, cy, rr;
    ax = longint'(q.a_x);  ay = longint'(q.a_y);
    aw = longint'(q.a_w);  ah = longint'(q.a_h);
    bx = longint'(q.b_x);  by = longint'(q.b_y);
    bw = longint'(q.b_w);  bh = longint'(q.b_h);
    cx = longint'(q.circle_x);  cy = longint'(q.circle_y);
    rr = longint'(q.circle_radius) * longint'(q.circle_radius);
    case (q.operation)
      rccol_pkg::OP_RECT_RECT: begin
        return !(ax > bx + bw || ax + aw < bx || ay > by + bh || ay + ah < by);
      end
      rccol_pkg::OP_RECT_CIRCLE: begin
        // rect wholly inside the circle misses the outline
        if (dist_sq(far_edge_of(ax, aw, cx), far_edge_of(ay, ah, cy), cx, cy) < rr)
          return 1'b0;
        return dist_sq(clamp_to_edge(ax, aw, cx), clamp_to_edge(ay, ah, cy), cx, cy) <= rr;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int srange(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Every field random; the unused operands carry noise
  function automatic query_t random_query(rccol_pkg::op_t op);
    query_t q;
    q.operation = op;
    q.a_x = rccol_pkg::coord_t'($urandom);  q.a_y = rccol_pkg::coord_t'($urandom);
    q.a_w = rccol_pkg::size_t'($urandom);   q.a_h = rccol_pkg::size_t'($urandom);
    q.b_x = rccol_pkg::coord_t'($urandom);  q.b_y = rccol_pkg::coord_t'($urandom);
    q.b_w = rccol_pkg::size_t'($urandom);   q.b_h = rccol_pkg::size_t'($urandom);
    q.circle_x = rccol_pkg::coord_t'($urandom);
    q.circle_y = rccol_pkg::coord_t'($urandom);
    q.circle_radius = rccol_pkg::size_t'($urandom);
    return q;
  endfunction

  function automatic query_t rect_pair(int ax, int ay, int aw, int ah,
                                      int bx, int by, int bw, int bh);
    query_t q;
    q = random_query(rccol_pkg::OP_RECT_RECT);
    q.a_x = rccol_pkg::coord_t'(ax);  q.a_y = rccol_pkg::coord_t'(ay);
    q.a_w = rccol_pkg::size_t'(aw);   q.a_h = rccol_pkg::size_t'(ah);
    q.b_x = rccol_pkg::coord_t'(bx);  q.b_y = rccol_pkg::coord_t'(by);
    q.b_w = rccol_pkg::size_t'(bw);   q.b_h = rccol_pkg::size_t'(bh);
    return q;
  endfunction

  function automatic query_t rect_circle(int ax, int ay, int aw, int ah,
                                        int cx, int cy, int r);
    query_t q;
    q = random_query(rccol_pkg::OP_RECT_CIRCLE);
    q.a_x = rccol_pkg::coord_t'(ax);  q.a_y = rccol_pkg::coord_t'(ay);
    q.a_w = rccol_pkg::size_t'(aw);   q.a_h = rccol_pkg::size_t'(ah);
    q.circle_x = rccol_pkg::coord_t'(cx);  q.circle_y = rccol_pkg::coord_t'(cy);
    q.circle_radius = rccol_pkg::size_t'(r);
    return q;
  endfunction

  // Drive one item after a random gap, hold it until taken, log its expected hit
  task automatic send_query(query_t q);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= q.operation;
    a_x <= q.a_x;  a_y <= q.a_y;  a_w <= q.a_w;  a_h <= q.a_h;
    b_x <= q.b_x;  b_y <= q.b_y;  b_w <= q.b_w;  b_h <= q.b_h;
    circle_x <= q.circle_x;  circle_y <= q.circle_y;  circle_radius <= q.circle_radius;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_hits.push_back(collision_hit(q));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_hits.size() != 0);
  endtask

  task automatic test_rect_rect_edges();
    send_query(rect_pair(0, 0, 10, 10, 5, 5, 10, 10));          // plain overlap
    send_query(rect_pair(0, 0, 10, 10, 10, 3, 4, 4));           // shared right edge
    send_query(rect_pair(0, 0, 10, 10, 10, 10, 0, 0));          // corner touch, point rect
    send_query(rect_pair(0, 0, 10, 10, 11, 0, 5, 5));           // one unit apart
    send_query(rect_pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
    send_query(rect_pair(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767));
    send_query(rect_pair(-32768, 100, 0, 0, -32768, 100, 0, 0)); // coincident points
  endtask

  task automatic test_rect_circle_edges();
    send_query(rect_circle(0, 0, 20, 20, 10, 10, 3));           // centre inside, small circle
    send_query(rect_circle(0, 0, 2, 2, 1, 1, 100));             // rect wholly inside circle
    send_query(rect_circle(0, 0, 3, 4, 0, 0, 5));               // far corner on the outline
    send_query(rect_circle(0, 0, 4, 4, 2, 2, 3));               // ties pick the low edges
    send_query(rect_circle(0, 0, 10, 10, 15, 5, 5));            // nearest point on radius
    send_query(rect_circle(0, 0, 10, 10, 16, 5, 5));            // just outside
    send_query(rect_circle(0, 0, 10, 10, 13, 14, 5));           // nearest corner on radius
    send_query(rect_circle(5, 5, 0, 0, 5, 5, 0));               // point on point
    send_query(rect_circle(-32768, -32768, 32767, 32767, 32767, 32767, 32767));
    send_query(rect_circle(32767, 32767, 32767, 32767, -32768, -32768, 32767));
    send_query(rect_circle(-32768, 32767, 0, 0, 32767, -32768, 0));
  endtask

  task automatic test_inert_operations();
    send_query(rect_pair(0, 0, 10, 10, 0, 0, 10, 10));
    send_query(random_query(rccol_pkg::OP_CIRCLE_CIRCLE));
    send_query(random_query(OP_UNUSED));
  endtask

  // Mostly nearby shape pairs so that every branch is reached, plus raw noise
  task automatic test_random_stream();
    query_t q;
    int pick, ax, ay, aw, ah, bw, bh, r;
    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_QUERIES / 2) drain_results();
      pick = $urandom_range(0, 99);
      aw = $urandom_range(0, 1000);  ah = $urandom_range(0, 1000);
      bw = $urandom_range(0, 1000);  bh = $urandom_range(0, 1000);
      if (pick < 15) begin
        q = random_query(rccol_pkg::op_t'($urandom_range(0, 3)));
      end else if (pick < 45) begin
        ax = srange(-30000, 30000);  ay = srange(-30000, 30000);
        if ($urandom_range(0, 3) == 0)
          q = rect_pair(ax, ay, aw, ah, ($urandom_range(0, 1) ? ax + aw : ax - bw),
                        ay + srange(-bh, ah), bw, bh);
        else
          q = rect_pair(ax, ay, aw, ah, ax + srange(-1100, 1100), ay + srange(-1100, 1100),
                        bw, bh);
      end else if (pick < 90) begin
        ax = srange(-30000, 28000);  ay = srange(-30000, 28000);
        r = $urandom_range(0, 1500);
        case ($urandom_range(0, 2))
          0: q = rect_circle(ax, ay, aw, ah, ax + srange(-1600, aw + 1600),
                             ay + srange(-1600, ah + 1600), r);
          1: q = rect_circle(ax, ay, aw, ah, ($urandom_range(0, 1) ? ax + aw + r : ax - r),
                             ay + srange(0, ah), r);
          default: q = rect_circle(ax, ay, aw, ah, ax + srange(0, aw), ay + srange(0, ah),
                                   $urandom_range(0, 2500));
        endcase
      end else begin
        q = random_query($urandom_range(0, 1) ? rccol_pkg::OP_CIRCLE_CIRCLE : OP_UNUSED);
      end
      send_query(q);
    end
    burst_mode = 1'b0;
  endtask

  // Result checker: each strobed hit against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, got hit=%0b", $time, hit);
        mismatch_count++;
      end else if (expected_hits[0] !== hit) begin
        $display("%0t: hit mismatch, expected %0b, got %0b", $time, expected_hits[0], hit);
        mismatch_count++;
        void'(expected_hits.pop_front());
      end else begin
        void'(expected_hits.pop_front());
      end
    end
  end

  // Watchdog on cycles with no item taken and no result seen
  always @(posedge clk) begin
    if ((start && !busy) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_rect_rect_edges();
    test_rect_circle_edges();
    test_inert_operations();
    test_random_stream();
    drain_results();
    repeat (PIPE_DRAIN) @(posedge clk);
    if (mismatch_count == 0 && expected_hits.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
